@@ rtl/mck_pkg.sv @@
`timescale 1ns / 1ps

package mck_pkg;

  localparam int TICK_W = 16;
  localparam int CHAR_W = 8;
  localparam int SYM_W  = 5;   // longest code: five symbols
  localparam int LEN_W  = 3;
  localparam int STEP_W = 4;
  localparam int IDX_W  = 3;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_DOT        = 3'd0;
  localparam logic [IDX_W-1:0] REG_DASH       = 3'd1;
  localparam logic [IDX_W-1:0] REG_SYMBOL_GAP = 3'd2;
  localparam logic [IDX_W-1:0] REG_LETTER_GAP = 3'd3;
  localparam logic [IDX_W-1:0] REG_WORD_GAP   = 3'd4;

  // reset timings in ticks
  localparam logic [TICK_W-1:0] RST_DOT        = 16'd200;
  localparam logic [TICK_W-1:0] RST_DASH       = 16'd600;
  localparam logic [TICK_W-1:0] RST_SYMBOL_GAP = 16'd200;
  localparam logic [TICK_W-1:0] RST_LETTER_GAP = 16'd600;
  localparam logic [TICK_W-1:0] RST_WORD_GAP   = 16'd1400;

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_STOP    = 8'h2E;

  // {length, symbols left-aligned with the first at the top bit}, 1 is a dash
  localparam logic [LEN_W+SYM_W-1:0] LETTER_TBL [0:25] = '{
    8'b010_01000, 8'b100_10000, 8'b100_10100, 8'b011_10000, 8'b001_00000,
    8'b100_00100, 8'b011_11000, 8'b100_00000, 8'b010_00000, 8'b100_01110,
    8'b011_10100, 8'b100_01000, 8'b010_11000, 8'b010_10000, 8'b011_11100,
    8'b100_01100, 8'b100_11010, 8'b011_01000, 8'b011_00000, 8'b001_10000,
    8'b011_00100, 8'b100_00010, 8'b011_01100, 8'b100_10010, 8'b100_10110,
    8'b100_11000
  };

  localparam logic [SYM_W-1:0] DIGIT_TBL [0:9] = '{
    5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001,
    5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110
  };

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_SYMBOLS,
    CLS_SPACE,
    CLS_STOP
  } char_class_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_SYMBOL,
    EMIT_SYMBOL_GAP,
    EMIT_LETTER_GAP,
    EMIT_WORD_GAP,
    EMIT_STOP
  } emit_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ACCEPT,
    COND_SPACE,
    COND_STOP,
    COND_NONE,
    COND_MORE
  } cond_t;

  typedef struct packed {
    logic  take;
    emit_t emit;
    logic  last;
    cond_t cond;
    step_t target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic  take;
    emit_t emit;
    logic  last;
    logic  fire;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic        accept;
    char_class_t cls;
    logic        more;
    logic        out_free;
  } stat_t;

  typedef struct packed {
    char_class_t      cls;
    logic [LEN_W-1:0] len;
    logic [SYM_W-1:0] pat;
  } dec_t;

  function automatic dec_t decode_char(input logic [CHAR_W-1:0] c);
    dec_t                    d;
    logic [CHAR_W-1:0]       off;
    logic [LEN_W+SYM_W-1:0]  ent;
    d   = '{cls: CLS_NONE, len: '0, pat: '0};
    off = '0;
    ent = '0;
    if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      off   = c - CH_UPPER_A;
      ent   = LETTER_TBL[off[4:0]];
      d.cls = CLS_SYMBOLS;
      d.len = ent[LEN_W+SYM_W-1:SYM_W];
      d.pat = ent[SYM_W-1:0];
    end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      off   = c - CH_LOWER_A;
      ent   = LETTER_TBL[off[4:0]];
      d.cls = CLS_SYMBOLS;
      d.len = ent[LEN_W+SYM_W-1:SYM_W];
      d.pat = ent[SYM_W-1:0];
    end else if (c inside {[CH_ZERO:CH_NINE]}) begin
      off   = c - CH_ZERO;
      d.cls = CLS_SYMBOLS;
      d.len = LEN_W'(SYM_W);
      d.pat = DIGIT_TBL[off[3:0]];
    end else if (c == CH_SPACE) begin
      d.cls = CLS_SPACE;
    end else if (c == CH_STOP) begin
      d.cls = CLS_STOP;
    end
    return d;
  endfunction

endpackage

@@ rtl/morse_character_keyer_top.sv @@
`timescale 1ns / 1ps

// Morse keyer: each input beat carries one ASCII code and produces the LED
// drive for it as a string of output beats, one per timed segment. Letters of
// either case and digits follow the ITU table: every dot or dash gives a lit
// segment (dot or dash time) then a dark symbol gap, and the character closes
// with a dark letter gap flagged as last segment. A space gives one dark
// segment of word-gap length, a full stop one zero-length segment with the
// stop flag, and any other code gives no beats at all. Timings live in five
// 16-bit registers (index 0 dot, 1 dash, 2 symbol gap, 3 letter gap, 4 word
// gap) written through cfg_we/cfg_index/cfg_wdata; the user must write them
// only while the keyer is idle, which the block itself does not enforce. Other
// indexes are ignored. Control is a nine-step microprogram: one character is
// in flight at a time, so the keyer takes no new character until its program
// is back at the wait step. Each segment step waits on the single output
// register, so output stalls hold the program at that step.

module morse_character_keyer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration writes
  input  logic                       cfg_we,
  input  logic [mck_pkg::IDX_W-1:0]  cfg_index,
  input  logic [mck_pkg::TICK_W-1:0] cfg_wdata,
  // character beats
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mck_pkg::CHAR_W-1:0] in_char_code,
  // segment beats
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_led_on,
  output logic [mck_pkg::TICK_W-1:0] out_duration_ticks,
  output logic                       out_is_dash,
  output logic                       out_stop_seen,
  output logic                       out_last_segment
);

  // control word of the current step, and status fed back for jumps
  mck_pkg::ctrl_t ctrl;
  mck_pkg::stat_t stat;

  // step counter and control store
  mck_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // timing registers, symbol shifter and output register
  mck_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_char_code       (in_char_code),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_led_on         (out_led_on),
    .out_duration_ticks (out_duration_ticks),
    .out_is_dash        (out_is_dash),
    .out_stop_seen      (out_stop_seen),
    .out_last_segment   (out_last_segment),
    .ctrl               (ctrl),
    .stat               (stat)
  );

  // only the wait step of the program takes a character
  assign in_ready = ctrl.take;

endmodule

@@ rtl/mck_seq.sv @@
`timescale 1ns / 1ps

module mck_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  mck_pkg::stat_t stat,
  output mck_pkg::ctrl_t ctrl
);

  localparam mck_pkg::step_t S_WAIT      = 4'd0;
  localparam mck_pkg::step_t S_IS_SPACE  = 4'd1;
  localparam mck_pkg::step_t S_IS_STOP   = 4'd2;
  localparam mck_pkg::step_t S_IS_NONE   = 4'd3;
  localparam mck_pkg::step_t S_SYMBOL    = 4'd4;
  localparam mck_pkg::step_t S_SYM_GAP   = 4'd5;
  localparam mck_pkg::step_t S_LET_GAP   = 4'd6;
  localparam mck_pkg::step_t S_WORD_GAP  = 4'd7;
  localparam mck_pkg::step_t S_STOP      = 4'd8;

  // control store
  function automatic mck_pkg::ucode_t ucode(input mck_pkg::step_t pc);
    mck_pkg::ucode_t u;
    case (pc)
      S_WAIT:     u = '{1'b1, mck_pkg::EMIT_NONE,       1'b0, mck_pkg::COND_NO_ACCEPT, S_WAIT};
      S_IS_SPACE: u = '{1'b0, mck_pkg::EMIT_NONE,       1'b0, mck_pkg::COND_SPACE,     S_WORD_GAP};
      S_IS_STOP:  u = '{1'b0, mck_pkg::EMIT_NONE,       1'b0, mck_pkg::COND_STOP,      S_STOP};
      S_IS_NONE:  u = '{1'b0, mck_pkg::EMIT_NONE,       1'b0, mck_pkg::COND_NONE,      S_WAIT};
      S_SYMBOL:   u = '{1'b0, mck_pkg::EMIT_SYMBOL,     1'b0, mck_pkg::COND_NEVER,     S_WAIT};
      S_SYM_GAP:  u = '{1'b0, mck_pkg::EMIT_SYMBOL_GAP, 1'b0, mck_pkg::COND_MORE,      S_SYMBOL};
      S_LET_GAP:  u = '{1'b0, mck_pkg::EMIT_LETTER_GAP, 1'b1, mck_pkg::COND_ALWAYS,    S_WAIT};
      S_WORD_GAP: u = '{1'b0, mck_pkg::EMIT_WORD_GAP,   1'b1, mck_pkg::COND_ALWAYS,    S_WAIT};
      S_STOP:     u = '{1'b0, mck_pkg::EMIT_STOP,       1'b1, mck_pkg::COND_ALWAYS,    S_WAIT};
      default:    u = '{1'b0, mck_pkg::EMIT_NONE,       1'b0, mck_pkg::COND_ALWAYS,    S_WAIT};
    endcase
    return u;
  endfunction

  mck_pkg::step_t  pc_r, pc_nxt;
  mck_pkg::ucode_t uw;
  logic            go;
  logic            cond_hit;

  assign uw = ucode(pc_r);

  // an emitting step holds until the output register can take the beat
  assign go = (uw.emit == mck_pkg::EMIT_NONE) || stat.out_free;

  always_comb begin
    case (uw.cond)
      mck_pkg::COND_NEVER:     cond_hit = 1'b0;
      mck_pkg::COND_ALWAYS:    cond_hit = 1'b1;
      mck_pkg::COND_NO_ACCEPT: cond_hit = !stat.accept;
      mck_pkg::COND_SPACE:     cond_hit = (stat.cls == mck_pkg::CLS_SPACE);
      mck_pkg::COND_STOP:      cond_hit = (stat.cls == mck_pkg::CLS_STOP);
      mck_pkg::COND_NONE:      cond_hit = (stat.cls == mck_pkg::CLS_NONE);
      mck_pkg::COND_MORE:      cond_hit = stat.more;
      default:                 cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (!go) begin
      pc_nxt = pc_r;
    end else if (cond_hit) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.take = uw.take;
  assign ctrl.emit = uw.emit;
  assign ctrl.last = uw.last;
  assign ctrl.fire = (uw.emit != mck_pkg::EMIT_NONE) && stat.out_free;

  a_pc_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= S_STOP)
    else $error("step counter left the program");

  a_accept_dispatch : assert property (@(posedge clk) disable iff (!rst_n)
    stat.accept |=> pc_r == S_IS_SPACE)
    else $error("accepted beat not dispatched");

  a_take_only_waiting : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.take |-> pc_r == S_WAIT)
    else $error("input taken outside wait step");

endmodule

@@ rtl/mck_dp.sv @@
`timescale 1ns / 1ps

module mck_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mck_pkg::IDX_W-1:0]        cfg_index,
  input  logic [mck_pkg::TICK_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  input  logic [mck_pkg::CHAR_W-1:0]       in_char_code,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_led_on,
  output logic [mck_pkg::TICK_W-1:0]       out_duration_ticks,
  output logic                             out_is_dash,
  output logic                             out_stop_seen,
  output logic                             out_last_segment,
  input  mck_pkg::ctrl_t                   ctrl,
  output mck_pkg::stat_t                   stat
);

  logic [mck_pkg::TICK_W-1:0] dot_r, dash_r, sym_gap_r, let_gap_r, word_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r      <= mck_pkg::RST_DOT;
      dash_r     <= mck_pkg::RST_DASH;
      sym_gap_r  <= mck_pkg::RST_SYMBOL_GAP;
      let_gap_r  <= mck_pkg::RST_LETTER_GAP;
      word_gap_r <= mck_pkg::RST_WORD_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        mck_pkg::REG_DOT:        dot_r      <= cfg_wdata;
        mck_pkg::REG_DASH:       dash_r     <= cfg_wdata;
        mck_pkg::REG_SYMBOL_GAP: sym_gap_r  <= cfg_wdata;
        mck_pkg::REG_LETTER_GAP: let_gap_r  <= cfg_wdata;
        mck_pkg::REG_WORD_GAP:   word_gap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // character held during its run
  logic                             accept;
  mck_pkg::dec_t                    dec;
  mck_pkg::char_class_t             cls_r;
  logic [mck_pkg::SYM_W-1:0]        pat_r;
  logic [mck_pkg::LEN_W-1:0]        cnt_r;
  logic                             shift;

  assign accept = in_valid && ctrl.take;
  assign dec    = mck_pkg::decode_char(in_char_code);
  assign shift  = ctrl.fire && (ctrl.emit == mck_pkg::EMIT_SYMBOL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= mck_pkg::CLS_NONE;
      cnt_r <= '0;
    end else if (accept) begin
      cls_r <= dec.cls;
      cnt_r <= dec.len;
    end else if (shift) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pat_r <= dec.pat;
    end else if (shift) begin
      pat_r <= {pat_r[mck_pkg::SYM_W-2:0], 1'b0};
    end
  end

  // output register
  logic                       out_valid_r;
  logic                       led_r, dash_flag_r, stop_r, last_r;
  logic [mck_pkg::TICK_W-1:0] dur_r;
  logic                       led_nxt, dash_flag_nxt, stop_nxt;
  logic [mck_pkg::TICK_W-1:0] dur_nxt;
  logic                       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    led_nxt       = 1'b0;
    dash_flag_nxt = 1'b0;
    stop_nxt      = 1'b0;
    dur_nxt       = '0;
    case (ctrl.emit)
      mck_pkg::EMIT_SYMBOL: begin
        led_nxt       = 1'b1;
        dash_flag_nxt = pat_r[mck_pkg::SYM_W-1];
        dur_nxt       = pat_r[mck_pkg::SYM_W-1] ? dash_r : dot_r;
      end
      mck_pkg::EMIT_SYMBOL_GAP: dur_nxt  = sym_gap_r;
      mck_pkg::EMIT_LETTER_GAP: dur_nxt  = let_gap_r;
      mck_pkg::EMIT_WORD_GAP:   dur_nxt  = word_gap_r;
      mck_pkg::EMIT_STOP:       stop_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      led_r       <= led_nxt;
      dash_flag_r <= dash_flag_nxt;
      stop_r      <= stop_nxt;
      last_r      <= ctrl.last;
      dur_r       <= dur_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_led_on         = led_r;
  assign out_duration_ticks = dur_r;
  assign out_is_dash        = dash_flag_r;
  assign out_stop_seen      = stop_r;
  assign out_last_segment   = last_r;

  assign stat.accept   = accept;
  assign stat.cls      = cls_r;
  assign stat.more     = (cnt_r != '0);
  assign stat.out_free = out_free;

  a_stop_shape : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && stop_r |-> dur_r == '0 && last_r && !led_r)
    else $error("stop beat malformed");

  a_dark_no_dash : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !led_r |-> !dash_flag_r)
    else $error("dash flag on a dark segment");

  a_symbol_has_count : assert property (@(posedge clk) disable iff (!rst_n)
    shift |-> cnt_r != '0)
    else $error("symbol sent with none left");

endmodule
